[rtl/ssan_pkg.sv]
// ----------------------------------------------------------------------------
// Strided slice axis normaliser package
// Shared constants and the side-band struct that rides through the divider.
// ----------------------------------------------------------------------------
package ssan_pkg;

    localparam int SIZE_BITS_DEF = 32;   // default value field width
    localparam int LEN_W         = 31;   // out_length width
    localparam int WIDE_W        = 64;   // out_stride / start_offset width

    typedef struct packed {
        logic signed [WIDE_W-1:0] out_stride;
        logic signed [WIDE_W-1:0] start_offset;
        logic                     drop_axis;
        logic                     bound_error;
    } t_side;

endpackage

[rtl/strided_slice_axis_normalizer.sv]
// ----------------------------------------------------------------------------
// Strided slice axis normaliser
// Python-style slice/index normalisation of one tensor axis: length, stride,
// start offset, drop flag and bound error.
// ----------------------------------------------------------------------------
// Pipeline: four front stages, then one divider stage per quotient bit.
// Throughput: one item per cycle unless the output stalls; every stage has its
//   own valid bit and stage-local ready, so bubbles close up while it is stalled.
// Reset: synchronous, active low; clears all stage valid bits only.
// ----------------------------------------------------------------------------
module strided_slice_axis_normalizer #(
    parameter int SIZE_BITS = ssan_pkg::SIZE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [30:0]                          i_axis_size,
    input  logic signed [31:0]                   i_axis_stride,
    input  logic                                 i_begin_given,
    input  logic signed [31:0]                   i_begin_value,
    input  logic                                 i_end_given,
    input  logic signed [31:0]                   i_end_value,
    input  logic                                 i_step_given,
    input  logic signed [31:0]                   i_step_value,
    input  logic                                 i_is_index,
    input  logic signed [31:0]                   i_index_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ssan_pkg::LEN_W-1:0]           o_out_length,
    output logic signed [ssan_pkg::WIDE_W-1:0]   o_out_stride,
    output logic signed [ssan_pkg::WIDE_W-1:0]   o_start_offset,
    output logic                                 o_drop_axis,
    output logic                                 o_bound_error
);

    localparam int W = SIZE_BITS;
    localparam int X = SIZE_BITS + 2;   // room for wrap sums and -1

    // wrap a negative bound once; a zero-size axis maps everything to 0
    function automatic logic signed [X-1:0] f_wrap(input logic signed [X-1:0] v,
                                                   input logic signed [X-1:0] sz);
        if (sz == '0) begin
            f_wrap = '0;
        end else if (v < 0) begin
            f_wrap = v + sz;
        end else begin
            f_wrap = v;
        end
    endfunction

    // ---------------- stage handshake ----------------
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_div_rdy;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_rdy4  = !r_v4 || w_div_rdy;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: field capture, sign extension ----------------
    logic signed [X-1:0] r1_size, r1_begin, r1_end, r1_step, r1_index;
    logic signed [W-1:0] r1_stride;
    logic                r1_bg, r1_eg, r1_sg, r1_idx;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_size   <= signed'(X'(i_axis_size[W-2:0]));
            r1_stride <= signed'(i_axis_stride[W-1:0]);
            r1_begin  <= X'(signed'(i_begin_value[W-1:0]));
            r1_end    <= X'(signed'(i_end_value[W-1:0]));
            r1_step   <= X'(signed'(i_step_value[W-1:0]));
            r1_index  <= X'(signed'(i_index_value[W-1:0]));
            r1_bg     <= i_begin_given;
            r1_eg     <= i_end_given;
            r1_sg     <= i_step_given;
            r1_idx    <= i_is_index;
        end
    end

    // ---------------- stage 2: defaults and wrap ----------------
    logic signed [X-1:0] n2_step, n2_bsel, n2_start, n2_stop, n2_index;
    logic signed [X-1:0] r2_size, r2_step, r2_start, r2_stop, r2_index;
    logic signed [W-1:0] r2_stride;
    logic                r2_idx;

    always_comb begin
        n2_step = r1_sg ? r1_step : X'(1);
        // a negative step starts by default at the last element
        if (r1_bg) begin
            n2_bsel = r1_begin;
        end else if (n2_step < 0) begin
            n2_bsel = r1_size - X'(1);
        end else begin
            n2_bsel = '0;
        end
        n2_start = f_wrap(n2_bsel, r1_size);
        // absent end: size going up, one before element 0 going down
        if (r1_eg) begin
            n2_stop = f_wrap(r1_end, r1_size);
        end else if (n2_step < 0) begin
            n2_stop = -X'(1);
        end else begin
            n2_stop = r1_size;
        end
        // index wraps once with no zero-size special case
        n2_index = (r1_index < 0) ? r1_index + r1_size : r1_index;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_size   <= r1_size;
            r2_step   <= n2_step;
            r2_start  <= n2_start;
            r2_stop   <= n2_stop;
            r2_index  <= n2_index;
            r2_stride <= r1_stride;
            r2_idx    <= r1_idx;
        end
    end

    // ---------------- stage 3: clamp and range checks ----------------
    logic signed [X-1:0] n3_top, n3_start, n3_stop;
    logic                n3_err;
    logic signed [X-1:0] r3_start, r3_stop, r3_step;
    logic signed [W-1:0] r3_stride;
    logic                r3_err, r3_idx;

    always_comb begin
        n3_top   = (r2_size > 0) ? r2_size - X'(1) : '0;
        n3_start = r2_start;
        n3_stop  = r2_stop;
        n3_err   = 1'b0;
        if (r2_idx) begin
            n3_start = r2_index;
            n3_err   = (r2_index < 0) || (r2_index >= r2_size);
        end else if (r2_step > 0) begin
            n3_stop  = (r2_stop > r2_size) ? r2_size : r2_stop;
            n3_start = (r2_start > n3_stop) ? n3_stop : r2_start;
            n3_err   = n3_start < 0;
        end else if (r2_step < 0) begin
            n3_start = (r2_start > n3_top) ? n3_top : r2_start;
            n3_stop  = (r2_stop > n3_start) ? n3_start : r2_stop;
            n3_err   = (n3_start < 0) || (n3_start >= r2_size) || (n3_stop < -X'(1));
        end else begin
            n3_err   = 1'b1;   // zero step
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_start  <= n3_start;
            r3_stop   <= n3_stop;
            r3_step   <= r2_step;
            r3_stride <= r2_stride;
            r3_err    <= n3_err;
            r3_idx    <= r2_idx;
        end
    end

    // ---------------- stage 4: span, |step|, both products ----------------
    logic signed [X-1:0]   n4_span, n4_abs;
    logic signed [W-1:0]   n4_step_w, n4_start_w;
    logic signed [2*W-1:0] n4_prod_s, n4_prod_o;
    logic [W-1:0]          r4_span, r4_abs;
    logic signed [2*W-1:0] r4_prod_s, r4_prod_o;
    logic                  r4_err, r4_idx;

    always_comb begin
        n4_span    = (r3_start >= r3_stop) ? r3_start - r3_stop : r3_stop - r3_start;
        n4_abs     = (r3_step < 0) ? -r3_step : r3_step;
        n4_step_w  = r3_step[W-1:0];
        n4_start_w = r3_start[W-1:0];
        n4_prod_s  = r3_stride * n4_step_w;
        n4_prod_o  = r3_stride * n4_start_w;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_span   <= n4_span[W-1:0];
            r4_abs    <= n4_abs[W-1:0];
            r4_prod_s <= n4_prod_s;
            r4_prod_o <= n4_prod_o;
            r4_err    <= r3_err;
            r4_idx    <= r3_idx;
        end
    end

    // ---------------- divider: ceil(span / |step|) ----------------
    logic [W-1:0]    w_num, w_den, w_quot;
    ssan_pkg::t_side w_side_in, w_side_out;

    always_comb begin
        // an index gives 1/1, an error 0/1, so the quotient is already final
        if (r4_err) begin
            w_num = '0;
            w_den = W'(1);
        end else if (r4_idx) begin
            w_num = W'(1);
            w_den = W'(1);
        end else begin
            w_num = r4_span + r4_abs - W'(1);
            w_den = r4_abs;
        end
        w_side_in.out_stride   = (r4_err || r4_idx) ? '0 : ssan_pkg::WIDE_W'(r4_prod_s);
        w_side_in.start_offset = r4_err ? '0 : ssan_pkg::WIDE_W'(r4_prod_o);
        w_side_in.drop_axis    = r4_idx;
        w_side_in.bound_error  = r4_err;
    end

    ssan_div #(
        .W (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (w_div_rdy),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_side_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_quot  (w_quot),
        .o_side  (w_side_out)
    );

    assign o_out_length   = ssan_pkg::LEN_W'(w_quot);
    assign o_out_stride   = w_side_out.out_stride;
    assign o_start_offset = w_side_out.start_offset;
    assign o_drop_axis    = w_side_out.drop_axis;
    assign o_bound_error  = w_side_out.bound_error;

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bound_error |->
            o_out_length == '0 && o_out_stride == '0 && o_start_offset == '0)
        else $error("bound error result not zeroed");

    a_index_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drop_axis && !o_bound_error |->
            o_out_length == ssan_pkg::LEN_W'(1) && o_out_stride == '0)
        else $error("index result has wrong length or stride");

    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted item missing from first stage");

    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !w_div_rdy |=> r_v4 && $stable(r4_span) && $stable(r4_err))
        else $error("stalled stage four item changed");

endmodule

[rtl/ssan_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, W stages, side-band carried with each item.
// ----------------------------------------------------------------------------
module ssan_div #(
    parameter int W = ssan_pkg::SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [W-1:0]         i_num,
    input  logic [W-1:0]         i_den,
    input  ssan_pkg::t_side      i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W-1:0]         o_quot,
    output ssan_pkg::t_side      o_side
);

    logic                r_v   [W];
    logic [2*W-1:0]      r_acc [W];   // {remainder, numerator/quotient}
    logic [W-1:0]        r_den [W];
    ssan_pkg::t_side     r_sd  [W];

    logic                w_rdy [W];
    logic [2*W-1:0]      n_acc [W];

    // one restoring step: shift in next numerator bit, try subtract
    function automatic logic [2*W-1:0] f_step(input logic [2*W-1:0] acc,
                                              input logic [W-1:0] den);
        logic [W:0] t;
        logic [W:0] d;
        t = {acc[2*W-1:W], acc[W-1]};
        d = {1'b0, den} ;
        if (t >= d) begin
            t = t - d;
            f_step = {t[W-1:0], acc[W-2:0], 1'b1};
        end else begin
            f_step = {t[W-1:0], acc[W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        w_rdy[W-1] = !r_v[W-1] || i_ready;
        for (int k = W-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        n_acc[0] = f_step({{W{1'b0}}, i_num}, i_den);
        for (int k = 1; k < W; k++) begin
            n_acc[k] = f_step(r_acc[k-1], r_den[k-1]);
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < W; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_acc[0] <= n_acc[0];
            r_den[0] <= i_den;
            r_sd[0]  <= i_side;
        end
        for (int k = 1; k < W; k++) begin
            if (w_rdy[k]) begin
                r_acc[k] <= n_acc[k];
                r_den[k] <= r_den[k-1];
                r_sd[k]  <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_acc[W-1][W-1:0];
    assign o_side  = r_sd[W-1];

endmodule
